// ----- rtl/nearest_palette_color_macros.svh -----
// Assertion macros for the nearest palette color block.
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds in the same cycle as its trigger.
`define NPC_ASSERT_NOW(lbl, clk_s, rst_s, trig, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |-> (cond)) \
    else $error("assertion failed");
// Check that a condition holds in the cycle after its trigger.
`define NPC_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define NPC_ASSERT_NOW(lbl, clk_s, rst_s, trig, cond)
`define NPC_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond)
`endif
`endif

// ----- rtl/npc_pkg.sv -----
package npc_pkg;

  localparam int unsigned PAL_ENTRIES = 64;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned ROOT_W      = 9;
  localparam int unsigned IDX_W       = 6;

  localparam logic [IDX_W-1:0]  REMAP_FROM = 6'h0D;
  localparam logic [IDX_W-1:0]  REMAP_TO   = 6'h0F;
  localparam logic [ROOT_W-1:0] DIST_FAR   = 9'h1FF;

  typedef logic [ROOT_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic [23:0] PALETTE [PAL_ENTRIES] = '{
    24'h7C7C7C, 24'h0000FC, 24'h0000BC, 24'h4428BC, 24'h940084, 24'hA80020, 24'hA81000,
    24'h881400, 24'h503000, 24'h007800, 24'h006800, 24'h005800, 24'h004058, 24'h000000,
    24'h000000, 24'h000000, 24'hBCBCBC, 24'h0078F8, 24'h0058F8, 24'h6844FC, 24'hD800CC,
    24'hE40058, 24'hF83800, 24'hE45C10, 24'hAC7C00, 24'h00B800, 24'h00A800, 24'h00A844,
    24'h008888, 24'h000000, 24'h000000, 24'h000000, 24'hF8F8F8, 24'h3CBCFC, 24'h6888FC,
    24'h9878F8, 24'hF878F8, 24'hF85898, 24'hF87858, 24'hFCA044, 24'hF8B800, 24'hB8F818,
    24'h58D854, 24'h58F898, 24'h00E8D8, 24'h787878, 24'h000000, 24'h000000, 24'hFCFCFC,
    24'hA4E4FC, 24'hB8B8F8, 24'hD8B8F8, 24'hF8B8F8, 24'hF8A4C0, 24'hF0D0B0, 24'hFCE0A8,
    24'hF8D878, 24'hD8F878, 24'hB8F8B8, 24'hB8F8D8, 24'h00FCFC, 24'hF8D8F8, 24'h000000,
    24'h000000
  };

endpackage

// ----- rtl/npc_isqrt.sv -----
module npc_isqrt
  import npc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] sum_i,
  output dist_t            root_o
);

  localparam int unsigned NSTG = 3;
  localparam int unsigned PER  = 3;

  logic [SUM_W-1:0]  rem_r  [NSTG];
  logic [ROOT_W-1:0] root_r [NSTG];
  logic [SUM_W-1:0]  rem_nxt  [NSTG];
  logic [ROOT_W-1:0] root_nxt [NSTG];

  // Three result bits per stage, highest bit first
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;

    // Take the radicand at the first stage, the previous stage after it
    if (s == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    always_comb begin
      logic [SUM_W+1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SUM_W+1:0]  trial;
      int                bp;
      rem  = {2'b00, rem_in};
      root = root_in;
      for (int k = 0; k < PER; k++) begin
        bp    = ROOT_W - 1 - s * PER - k;
        trial = ((SUM_W+2)'(root) << (bp + 1)) | ((SUM_W+2)'(1) << (2 * bp));
        if (rem >= trial) begin
          rem  = rem - trial;
          root = root | (ROOT_W'(1) << bp);
        end
      end
      rem_nxt[s]  = rem[SUM_W-1:0];
      root_nxt[s] = root;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign root_o = root_r[NSTG-1];

endmodule

// ----- rtl/nearest_palette_color.sv -----
// Nearest palette color: maps one RGB pixel to the index of the closest of
// the first PALETTE_SIZE (default 64) fixed palette colors, by floor of the
// Euclidean distance, lowest index on a tie, with index 13 reported as 15.
// Input channel: in_tvalid/in_tready/in_tdata, red in [7:0], green in
// [15:8], blue in [23:16]. Result channel: out_tvalid/out_tready/out_tdata,
// palette index in [5:0], upper bits zero.
// A pixel passes the register pipeline of square, sum, three square-root
// stages, three compare-tree stages and output. One pixel is accepted every
// cycle while out_tready does not stall the pipeline.
// All stages advance together, so a stall on out_tready freezes the whole
// pipeline and drops in_tready; nothing is lost or repeated.
// Reset clears all valid bits; the block then accepts at once.
`include "nearest_palette_color_macros.svh"
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_level, green_level, blue_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // palette_index, zero pad
);

  localparam int unsigned NV   = 9;
  localparam int unsigned LVLS = 6;

  logic [NV-1:0] vld_r;
  logic [NV-1:0] vld_nxt;
  logic          adv;

  assign adv       = !vld_r[NV-1] || out_tready;
  assign in_tready = adv;

  // Shift valid bits along with the data
  assign vld_nxt = {vld_r[NV-2:0], in_tvalid};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  logic [15:0]      sq_r  [PAL_ENTRIES][3];
  logic [SUM_W-1:0] sum_r [PAL_ENTRIES];
  dist_t            root  [PAL_ENTRIES];

  dist_t lv_dist [LVLS+1][PAL_ENTRIES];
  idx_t  lv_idx  [LVLS+1][PAL_ENTRIES];

  for (genvar e = 0; e < PAL_ENTRIES; e++) begin : g_ent
    // Square the channel gaps
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [7:0] px;
      logic [7:0] pc;
      logic [7:0] gap;
      assign px  = in_tdata[c*8 +: 8];
      assign pc  = PALETTE[e][(2-c)*8 +: 8];
      assign gap = (px > pc) ? (px - pc) : (pc - px);
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_r[e][c] <= 16'(gap) * 16'(gap);
        end
      end
    end

    // Add the squares
    always_ff @(posedge clk) begin
      if (adv) begin
        sum_r[e] <= SUM_W'(sq_r[e][0]) + SUM_W'(sq_r[e][1]) + SUM_W'(sq_r[e][2]);
      end
    end

    npc_isqrt u_isqrt (
      .clk    (clk),
      .en     (adv),
      .sum_i  (sum_r[e]),
      .root_o (root[e])
    );

    // Entries past the searched range never win
    if (e < PALETTE_SIZE) begin : g_live
      assign lv_dist[0][e] = root[e];
    end else begin : g_dead
      assign lv_dist[0][e] = DIST_FAR;
    end
    assign lv_idx[0][e] = IDX_W'(e);
  end

  // Compare tree, registered after every second level
  for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
    for (genvar n = 0; n < PAL_ENTRIES; n++) begin : g_node
      if (n < (PAL_ENTRIES >> l)) begin : g_used
        logic  pick_hi;
        dist_t d_sel;
        idx_t  i_sel;
        assign pick_hi = lv_dist[l-1][2*n+1] < lv_dist[l-1][2*n];
        assign d_sel   = pick_hi ? lv_dist[l-1][2*n+1] : lv_dist[l-1][2*n];
        assign i_sel   = pick_hi ? lv_idx[l-1][2*n+1]  : lv_idx[l-1][2*n];
        if (l % 2 == 1) begin : g_comb
          assign lv_dist[l][n] = d_sel;
          assign lv_idx[l][n]  = i_sel;
        end else begin : g_reg
          dist_t d_r;
          idx_t  i_r;
          always_ff @(posedge clk) begin
            if (adv) begin
              d_r <= d_sel;
              i_r <= i_sel;
            end
          end
          assign lv_dist[l][n] = d_r;
          assign lv_idx[l][n]  = i_r;
        end
      end else begin : g_unused
        assign lv_dist[l][n] = DIST_FAR;
        assign lv_idx[l][n]  = '0;
      end
    end
  end

  // Remap the winner and hold it for the receiver
  idx_t out_idx_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r <= (lv_idx[LVLS][0] == REMAP_FROM) ? REMAP_TO : lv_idx[LVLS][0];
    end
  end

  assign out_tvalid = vld_r[NV-1];
  assign out_tdata  = {2'b00, out_idx_r};

  // An empty search reports index zero
  logic idx_ok;
  assign idx_ok = (out_idx_r < PALETTE_SIZE) || (out_idx_r == REMAP_TO) || (out_idx_r == '0);

  `NPC_ASSERT_NOW(a_no_raw_13, clk, rst_n, out_tvalid, out_tdata[5:0] != REMAP_FROM)
  `NPC_ASSERT_NOW(a_idx_range, clk, rst_n, out_tvalid, idx_ok)
  `NPC_ASSERT_NOW(a_ready_rule, clk, rst_n, 1'b1, in_tready == (!out_tvalid || out_tready))
  `NPC_ASSERT_NEXT(a_freeze, clk, rst_n, !adv, vld_r == $past(vld_r))

endmodule
